/* rtl/cgvu_pkg.sv */
// Shared types and constants for the central gravity velocity update core.
// No dependencies; imported by every module of the core.
`default_nettype none

package cgvu_pkg;

	// register indexes of the configuration port
	localparam logic [1:0] REG_GRAV_CONSTANT = 2'd0;
	localparam logic [1:0] REG_CENTRAL_MASS  = 2'd1;
	localparam logic [1:0] REG_MIN_DISTANCE  = 2'd2;
	localparam logic [1:0] REG_TIME_STEP     = 2'd3;

	// reset values: G = 100.0, M = 1000.0 (Q16.8), rmin ~ 0.1, dt ~ 1/60 (Q16.16)
	localparam logic [23:0] GRAV_CONSTANT_RST = 24'd25600;
	localparam logic [23:0] CENTRAL_MASS_RST  = 24'd256000;
	localparam logic [31:0] MIN_DISTANCE_RST  = 32'd6554;
	localparam logic [31:0] TIME_STEP_RST     = 32'd1092;

	// pipeline stage counts of the iterative units
	localparam int SQRT_STAGES = 32;
	localparam int QUOT_BITS   = 49;
	localparam int DIV_STAGES  = QUOT_BITS + 1;

	// per-body values that ride along the long units
	typedef struct packed {
		logic [31:0] vel_x;
		logic [31:0] vel_y;
		logic [31:0] abs_x;
		logic [31:0] abs_y;
		logic        sub_x;
		logic        sub_y;
		logic        inv_nz;
	} body_t;

	typedef struct packed {
		body_t        body;
		logic [127:0] num;
		logic [63:0]  dist_sq;
	} sqrt_side_t;

	typedef struct packed {
		body_t body;
		logic  force_on;
	} div_side_t;

endpackage

`default_nettype wire

/* rtl/central_gravity_velocity_update_core.sv */
// Top level of the central gravity velocity update core.
// Depends on cgvu_pkg, cgvu_sqrt and cgvu_div.
//
// channel  dir  handshake          payload
// s_*      in   tvalid / tready    one body (position, velocity, masses)
// m_*      out  tvalid / tready    updated velocity and status flags
// cfg_*    in   cfg_we             register index and write data
//
// One body enters per cycle while the output is not stalled; each result passes through
// the 32-stage square root and the 50-stage divider plus 10 arithmetic stages.
// Reset clears the stage valid bits and loads the register defaults.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated.
`default_nettype none

module central_gravity_velocity_update_core import cgvu_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// pos_x, pos_y, vel_x, vel_y, body_mass, inverse_mass
	input  wire logic [175:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// new_vel_x, new_vel_y
	output logic [63:0]       m_tdata,
	// force_applied, saturated
	output logic [1:0]        m_tuser,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);

	localparam logic [33:0] MAG_CAP = 34'h2_0000_0000;

	logic [23:0] grav_q;
	logic [23:0] cmass_q;
	logic [31:0] min_dist_q;
	logic [31:0] dt_q;

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q     <= GRAV_CONSTANT_RST;
			cmass_q    <= CENTRAL_MASS_RST;
			min_dist_q <= MIN_DISTANCE_RST;
			dt_q       <= TIME_STEP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRAV_CONSTANT: grav_q     <= cfg_data[23:0];
				REG_CENTRAL_MASS:  cmass_q    <= cfg_data[23:0];
				REG_MIN_DISTANCE:  min_dist_q <= cfg_data;
				REG_TIME_STEP:     dt_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// input unpack
	logic [31:0] pos_x, pos_y, vel_x, vel_y;
	logic [23:0] body_mass, inverse_mass;
	assign pos_x        = s_tdata[31:0];
	assign pos_y        = s_tdata[63:32];
	assign vel_x        = s_tdata[95:64];
	assign vel_y        = s_tdata[127:96];
	assign body_mass    = s_tdata[151:128];
	assign inverse_mass = s_tdata[175:152];

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic sq_valid, dv_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0; v_s10 <= 1'b0;
		end else if (adv) begin
			v_s1  <= s_tvalid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= sq_valid;
			v_s7  <= v_s6;
			v_s8  <= dv_valid;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	// stage 1: absolute distances, mass product, G*M
	body_t       body_s1;
	logic [47:0] mi_s1, gm_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			body_s1.vel_x  <= vel_x;
			body_s1.vel_y  <= vel_y;
			body_s1.abs_x  <= pos_x[31] ? ~pos_x + 32'd1 : pos_x;
			body_s1.abs_y  <= pos_y[31] ? ~pos_y + 32'd1 : pos_y;
			body_s1.sub_x  <= !pos_x[31];
			body_s1.sub_y  <= !pos_y[31];
			body_s1.inv_nz <= inverse_mass != 24'd0;
			mi_s1          <= body_mass * inverse_mass;
			gm_s1          <= grav_q * cmass_q;
		end
	end

	// stage 2: squares and partial products of G*M*m*inv
	body_t       body_s2;
	logic [63:0] sqx_s2, sqy_s2;
	logic [47:0] pp0_s2, pp1_s2, pp2_s2, pp3_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			body_s2 <= body_s1;
			sqx_s2  <= body_s1.abs_x * body_s1.abs_x;
			sqy_s2  <= body_s1.abs_y * body_s1.abs_y;
			pp0_s2  <= mi_s1[23:0]  * gm_s1[23:0];
			pp1_s2  <= mi_s1[23:0]  * gm_s1[47:24];
			pp2_s2  <= mi_s1[47:24] * gm_s1[23:0];
			pp3_s2  <= mi_s1[47:24] * gm_s1[47:24];
		end
	end

	// stage 3: sum squares and partials
	body_t       body_s3;
	logic [63:0] dsq_s3;
	logic [95:0] gmmi_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			body_s3 <= body_s2;
			dsq_s3  <= sqx_s2 + sqy_s2;
			gmmi_s3 <= {48'd0, pp0_s2} + ({48'd0, pp1_s2} << 24)
				+ ({48'd0, pp2_s2} << 24) + ({48'd0, pp3_s2} << 48);
		end
	end

	// stage 4: partial products with the time step
	body_t       body_s4;
	logic [63:0] dsq_s4, t0_s4, t1_s4, t2_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			body_s4 <= body_s3;
			dsq_s4  <= dsq_s3;
			t0_s4   <= gmmi_s3[31:0]  * dt_q;
			t1_s4   <= gmmi_s3[63:32] * dt_q;
			t2_s4   <= gmmi_s3[95:64] * dt_q;
		end
	end

	// stage 5: full numerator
	sqrt_side_t sq_in_s5;
	always_ff @(posedge clk) begin
		if (adv) begin
			sq_in_s5.body    <= body_s4;
			sq_in_s5.dist_sq <= dsq_s4;
			sq_in_s5.num     <= {64'd0, t0_s4} + ({64'd0, t1_s4} << 32) + ({64'd0, t2_s4} << 64);
		end
	end

	logic [31:0] root;
	sqrt_side_t  sq_out;

	cgvu_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v_s5),
		.in_side   (sq_in_s5),
		.out_valid (sq_valid),
		.out_root  (root),
		.out_side  (sq_out)
	);

	// stage 6: distance gate and denominator partials
	div_side_t    dside_s6;
	logic [127:0] num_s6;
	logic [63:0]  dlo_s6, dhi_s6;
	always_ff @(posedge clk) begin
		if (adv) begin
			dside_s6.body     <= sq_out.body;
			dside_s6.force_on <= sq_out.body.inv_nz && (root > min_dist_q);
			num_s6            <= sq_out.num;
			dlo_s6            <= sq_out.dist_sq[31:0]  * root;
			dhi_s6            <= sq_out.dist_sq[63:32] * root;
		end
	end

	// stage 7: denominator
	div_side_t    dside_s7;
	logic [127:0] num_s7;
	logic [95:0]  den_s7;
	always_ff @(posedge clk) begin
		if (adv) begin
			dside_s7 <= dside_s6;
			num_s7   <= num_s6;
			den_s7   <= {32'd0, dlo_s6} + ({32'd0, dhi_s6} << 32);
		end
	end

	logic [QUOT_BITS-1:0] quot;
	logic                 big;
	div_side_t            dv_out;

	cgvu_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v_s7),
		.in_num    (num_s7),
		.in_den    (den_s7),
		.in_side   (dside_s7),
		.out_valid (dv_valid),
		.out_quot  (quot),
		.out_big   (big),
		.out_side  (dv_out)
	);

	// stage 8: quotient times distance components
	div_side_t   side_s8;
	logic        big_s8;
	logic [63:0] mxl_s8, myl_s8;
	logic [48:0] mxh_s8, myh_s8;
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s8 <= dv_out;
			big_s8  <= big;
			mxl_s8  <= quot[31:0] * dv_out.body.abs_x;
			myl_s8  <= quot[31:0] * dv_out.body.abs_y;
			mxh_s8  <= quot[48:32] * dv_out.body.abs_x;
			myh_s8  <= quot[48:32] * dv_out.body.abs_y;
		end
	end

	// stage 9: scale and cap increments
	logic [80:0] fx, fy;
	logic [33:0] magx_n, magy_n;
	assign fx = {17'd0, mxl_s8} + {mxh_s8, 32'd0};
	assign fy = {17'd0, myl_s8} + {myh_s8, 32'd0};

	always_comb begin
		if (side_s8.body.abs_x == 32'd0)
			magx_n = 34'd0;
		else if (big_s8 || fx[80:16] > {31'd0, MAG_CAP})
			magx_n = MAG_CAP;
		else
			magx_n = fx[49:16];
		if (side_s8.body.abs_y == 32'd0)
			magy_n = 34'd0;
		else if (big_s8 || fy[80:16] > {31'd0, MAG_CAP})
			magy_n = MAG_CAP;
		else
			magy_n = fy[49:16];
	end

	div_side_t   side_s9;
	logic [33:0] magx_s9, magy_s9;
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s9 <= side_s8;
			magx_s9 <= magx_n;
			magy_s9 <= magy_n;
		end
	end

	// stage 10: apply increments and clamp
	logic [35:0] sumx, sumy;
	logic        clx, cly;
	logic [31:0] nvx, nvy;
	always_comb begin
		sumx = side_s9.body.sub_x
			? {{4{side_s9.body.vel_x[31]}}, side_s9.body.vel_x} - {2'd0, magx_s9}
			: {{4{side_s9.body.vel_x[31]}}, side_s9.body.vel_x} + {2'd0, magx_s9};
		sumy = side_s9.body.sub_y
			? {{4{side_s9.body.vel_y[31]}}, side_s9.body.vel_y} - {2'd0, magy_s9}
			: {{4{side_s9.body.vel_y[31]}}, side_s9.body.vel_y} + {2'd0, magy_s9};
		clx = !((sumx[35:31] == 5'b00000) || (sumx[35:31] == 5'b11111));
		cly = !((sumy[35:31] == 5'b00000) || (sumy[35:31] == 5'b11111));
		nvx = clx ? (sumx[35] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sumx[31:0];
		nvy = cly ? (sumy[35] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sumy[31:0];
	end

	logic [31:0] nvx_s10, nvy_s10;
	logic        force_s10, sat_s10;
	always_ff @(posedge clk) begin
		if (adv) begin
			if (side_s9.force_on) begin
				nvx_s10   <= nvx;
				nvy_s10   <= nvy;
				force_s10 <= 1'b1;
				sat_s10   <= clx || cly;
			end else begin
				nvx_s10   <= side_s9.body.vel_x;
				nvy_s10   <= side_s9.body.vel_y;
				force_s10 <= 1'b0;
				sat_s10   <= 1'b0;
			end
		end
	end

	assign m_tvalid = v_s10;
	assign m_tdata  = {nvy_s10, nvx_s10};
	assign m_tuser  = {sat_s10, force_s10};

endmodule

`default_nettype wire

/* rtl/cgvu_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
// Depends on cgvu_pkg for the stage count and the carried side data.
`default_nettype none

module cgvu_sqrt import cgvu_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        adv,
	input  wire logic        in_valid,
	input  wire sqrt_side_t  in_side,
	output logic             out_valid,
	output logic [31:0]      out_root,
	output sqrt_side_t       out_side
);

	logic        vld_sk  [SQRT_STAGES+1];
	logic [63:0] rem_sk  [SQRT_STAGES+1];
	logic [63:0] res_sk  [SQRT_STAGES+1];
	sqrt_side_t  side_sk [SQRT_STAGES+1];

	// feed the first stage straight from the input
	assign vld_sk[0]  = in_valid;
	assign rem_sk[0]  = in_side.dist_sq;
	assign res_sk[0]  = 64'd0;
	assign side_sk[0] = in_side;

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
		localparam logic [63:0] BITV = 64'd1 << (2 * (SQRT_STAGES - 1 - k));
		logic [63:0] trial;
		logic [63:0] rem_n;
		logic [63:0] res_n;

		// try the next root bit
		always_comb begin
			trial = res_sk[k] + BITV;
			if (rem_sk[k] >= trial) begin
				rem_n = rem_sk[k] - trial;
				res_n = (res_sk[k] >> 1) + BITV;
			end else begin
				rem_n = rem_sk[k];
				res_n = res_sk[k] >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[k+1] <= 1'b0;
			end else if (adv) begin
				vld_sk[k+1] <= vld_sk[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_sk[k+1]  <= rem_n;
				res_sk[k+1]  <= res_n;
				side_sk[k+1] <= side_sk[k];
			end
		end
	end

	assign out_valid = vld_sk[SQRT_STAGES];
	assign out_root  = res_sk[SQRT_STAGES][31:0];
	assign out_side  = side_sk[SQRT_STAGES];

endmodule

`default_nettype wire

/* rtl/cgvu_div.sv */
// Pipelined restoring divider: overflow check, then one quotient bit per stage.
// Depends on cgvu_pkg for the quotient width and the carried side data.
`default_nettype none

module cgvu_div import cgvu_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           adv,
	input  wire logic           in_valid,
	input  wire logic [127:0]   in_num,
	input  wire logic [95:0]    in_den,
	input  wire div_side_t      in_side,
	output logic                out_valid,
	output logic [QUOT_BITS-1:0] out_quot,
	output logic                out_big,
	output div_side_t           out_side
);

	logic                 vld_sk  [DIV_STAGES+1];
	logic [127:0]         rem_sk  [DIV_STAGES+1];
	logic [95:0]          den_sk  [DIV_STAGES+1];
	logic [QUOT_BITS-1:0] quot_sk [DIV_STAGES+1];
	logic                 big_sk  [DIV_STAGES+1];
	div_side_t            side_sk [DIV_STAGES+1];

	assign vld_sk[0]  = in_valid;
	assign rem_sk[0]  = in_num;
	assign den_sk[0]  = in_den;
	assign quot_sk[0] = '0;
	assign big_sk[0]  = 1'b0;
	assign side_sk[0] = in_side;

	// flag quotients that reach the magnitude cap
	logic big_n;
	assign big_n = {17'd0, in_num} >= {in_den, {QUOT_BITS{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sk[1] <= 1'b0;
		end else if (adv) begin
			vld_sk[1] <= vld_sk[0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_sk[1]  <= rem_sk[0];
			den_sk[1]  <= den_sk[0];
			quot_sk[1] <= quot_sk[0];
			big_sk[1]  <= big_n;
			side_sk[1] <= side_sk[0];
		end
	end

	for (genvar k = 1; k < DIV_STAGES; k++) begin : g_stage
		localparam int SH = DIV_STAGES - 1 - k;
		logic [144:0] dsh;
		logic         take;

		// compare against the divisor aligned to this quotient bit
		assign dsh  = {49'd0, den_sk[k]} << SH;
		assign take = {17'd0, rem_sk[k]} >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[k+1] <= 1'b0;
			end else if (adv) begin
				vld_sk[k+1] <= vld_sk[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_sk[k+1]  <= take ? rem_sk[k] - dsh[127:0] : rem_sk[k];
				den_sk[k+1]  <= den_sk[k];
				quot_sk[k+1] <= {quot_sk[k][QUOT_BITS-2:0], take};
				big_sk[k+1]  <= big_sk[k];
				side_sk[k+1] <= side_sk[k];
			end
		end
	end

	assign out_valid = vld_sk[DIV_STAGES];
	assign out_quot  = quot_sk[DIV_STAGES];
	assign out_big   = big_sk[DIV_STAGES];
	assign out_side  = side_sk[DIV_STAGES];

endmodule

`default_nettype wire

/* dv/tb_central_gravity_velocity_update_core.sv */
// Self-checking testbench for central_gravity_velocity_update_core.
// Predicts each body's updated velocity with exact wide integer arithmetic and
// checks every output transfer in order; depends on cgvu_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_central_gravity_velocity_update_core;
	import cgvu_pkg::*;

	typedef struct {
		logic [31:0] vel_x;
		logic [31:0] vel_y;
		logic        force_on;
		logic        clamped;
	} vel_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// pos_x, pos_y, vel_x, vel_y, body_mass, inverse_mass
	logic [175:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// new_vel_x, new_vel_y
	logic [63:0] m_tdata;
	// force_applied, saturated
	logic [1:0] m_tuser;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_GRAV_CONSTANT;
	logic [31:0] cfg_data = '0;

	// register copies used by the predictor
	logic [23:0] grav_g = GRAV_CONSTANT_RST;
	logic [23:0] attractor_m = CENTRAL_MASS_RST;
	logic [31:0] rmin = MIN_DISTANCE_RST;
	logic [31:0] dt = TIME_STEP_RST;

	logic [175:0] bodies_pending[$];
	vel_result_t  velocities_due[$];
	int unsigned  cycle_count = 0;
	int unsigned  mismatches = 0;
	int unsigned  bodies_checked = 0;
	int unsigned  pulls_seen = 0;
	int unsigned  clamps_seen = 0;

	central_gravity_velocity_update_core DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// idle at random about 19 times in a hundred, except in one long busy stretch
	function automatic logic take_gap();
		if (cycle_count > 1500 && cycle_count < 2600) return 1'b0;
		return $urandom_range(0, 99) < 19;
	endfunction

	function automatic logic [63:0] floor_sqrt(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] trial;
		res = '0;
		for (int i = 31; i >= 0; i--) begin
			trial = res | (64'd1 << i);
			if (trial * trial <= v) res = trial;
		end
		return res;
	endfunction

	// add the pull along one axis, saturating to 32 signed bits
	function automatic logic [31:0] pull_axis(logic signed [63:0] vel, logic signed [63:0] pos,
			logic [127:0] q, inout logic clamped);
		logic [63:0] ad;
		logic [127:0] prod;
		logic signed [63:0] mag;
		logic signed [63:0] sum;
		ad = pos < 0 ? -pos : pos;
		mag = 0;
		if (ad != 0) begin
			if (q >= (128'd1 << 49)) begin
				mag = 64'sd1 << 33;
			end else begin
				prod = q * ad;
				mag = prod[79:16];
				if (mag > (64'sd1 << 33)) mag = 64'sd1 << 33;
			end
		end
		sum = pos > 0 ? vel - mag : vel + mag;
		if (sum > 64'sd2147483647) begin
			sum = 64'sd2147483647;
			clamped = 1'b1;
		end else if (sum < -64'sd2147483648) begin
			sum = -64'sd2147483648;
			clamped = 1'b1;
		end
		return sum[31:0];
	endfunction

	function automatic vel_result_t predict_velocity(logic [175:0] d);
		logic signed [63:0] px, py, vx, vy;
		logic [63:0] ax, ay, dsq, radius;
		logic [127:0] num, den, q;
		vel_result_t r;
		px = $signed(d[31:0]);
		py = $signed(d[63:32]);
		vx = $signed(d[95:64]);
		vy = $signed(d[127:96]);
		ax = px < 0 ? -px : px;
		ay = py < 0 ? -py : py;
		dsq = ax * ax + ay * ay;
		radius = floor_sqrt(dsq);
		r.vel_x = d[95:64];
		r.vel_y = d[127:96];
		r.force_on = 1'b0;
		r.clamped = 1'b0;
		if (d[175:152] != 0 && radius > rmin) begin
			num = 128'(grav_g) * 128'(attractor_m) * 128'(d[151:128]) * 128'(d[175:152])
				* 128'(dt);
			den = 128'(dsq) * 128'(radius);
			q = num / den;
			r.vel_x = pull_axis(vx, px, q, r.clamped);
			r.vel_y = pull_axis(vy, py, q, r.clamped);
			r.force_on = 1'b1;
		end
		return r;
	endfunction

	function automatic logic [175:0] body(logic [31:0] px, logic [31:0] py, logic [31:0] vx,
			logic [31:0] vy, logic [23:0] mass, logic [23:0] inv);
		return {inv, mass, vy, vx, py, px};
	endfunction

	function automatic logic [31:0] rand_coord();
		logic [31:0] mag;
		if ($urandom_range(0, 9) < 3) return $urandom;
		mag = $urandom >> $urandom_range(4, 24);
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	function automatic logic [175:0] rand_body();
		logic [31:0] vx, vy;
		logic [23:0] mass, inv;
		vx = $urandom_range(0, 9) < 3 ? $urandom : 32'($signed(16'($urandom)) * 16);
		vy = $urandom_range(0, 9) < 3 ? $urandom : 32'($signed(16'($urandom)) * 16);
		mass = $urandom_range(0, 1) ? 24'($urandom) : 24'(24'd65536 >> $urandom_range(0, 8));
		case ($urandom_range(0, 19))
			0: inv = '0;
			1, 2, 3, 4, 5, 6, 7, 8: inv = 24'($urandom);
			default: inv = 24'(24'd65536 >> $urandom_range(0, 8));
		endcase
		return body(rand_coord(), rand_coord(), vx, vy, mass, inv);
	endfunction

	// driver: record the expectation on each input transfer, hold valid until taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				velocities_due.push_back(predict_velocity(s_tdata));
				void'(bodies_pending.pop_front());
			end
			if (s_tvalid && !s_tready) begin
				// hold the current transfer
			end else if (bodies_pending.size() > 0 && !take_gap()) begin
				s_tvalid <= 1'b1;
				s_tdata <= bodies_pending[0];
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor: check each output transfer against the oldest expectation
	always @(posedge clk) begin
		vel_result_t exp_r;
		if (arst_n) begin
			m_tready <= !take_gap();
			if (m_tvalid && m_tready) begin
				if (velocities_due.size() == 0) begin
					$display("%0t: unexpected result vel %h tuser %b", $time, m_tdata, m_tuser);
					mismatches++;
				end else begin
					exp_r = velocities_due.pop_front();
					bodies_checked++;
					pulls_seen += exp_r.force_on;
					clamps_seen += exp_r.clamped;
					if (m_tdata[31:0] !== exp_r.vel_x) begin
						$display("%0t: new_vel_x expected %h actual %h", $time, exp_r.vel_x,
							m_tdata[31:0]);
						mismatches++;
					end
					if (m_tdata[63:32] !== exp_r.vel_y) begin
						$display("%0t: new_vel_y expected %h actual %h", $time, exp_r.vel_y,
							m_tdata[63:32]);
						mismatches++;
					end
					if (m_tuser[0] !== exp_r.force_on) begin
						$display("%0t: force_applied expected %b actual %b", $time,
							exp_r.force_on, m_tuser[0]);
						mismatches++;
					end
					if (m_tuser[1] !== exp_r.clamped) begin
						$display("%0t: saturated expected %b actual %b", $time,
							exp_r.clamped, m_tuser[1]);
						mismatches++;
					end
				end
			end
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_GRAV_CONSTANT: grav_g = val[23:0];
			REG_CENTRAL_MASS:  attractor_m = val[23:0];
			REG_MIN_DISTANCE:  rmin = val;
			REG_TIME_STEP:     dt = val;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait for every result, then let the pipeline drain fully
	task automatic drain();
		while (bodies_pending.size() > 0 || velocities_due.size() > 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic run_phase(logic [31:0] g, logic [31:0] m, logic [31:0] rm, logic [31:0] step,
			int count);
		write_reg(REG_GRAV_CONSTANT, g);
		write_reg(REG_CENTRAL_MASS, m);
		write_reg(REG_MIN_DISTANCE, rm);
		write_reg(REG_TIME_STEP, step);
		@(negedge clk);
		for (int i = 0; i < count; i++) bodies_pending.push_back(rand_body());
		drain();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// directed bodies at the reset register values
		bodies_pending.push_back(body(0, 0, 32'h1234_5678, 32'h8765_4321, 24'h010000, 24'h010000));
		bodies_pending.push_back(body(32'h000A_0000, 0, 0, 0, 24'h010000, 24'h000000));
		bodies_pending.push_back(body(32'd6554, 0, 0, 0, 24'h010000, 24'h010000));
		bodies_pending.push_back(body(32'd6555, 0, 0, 0, 24'h010000, 24'h010000));
		bodies_pending.push_back(body(0, 32'hFFFF_E666, 0, 0, 24'h010000, 24'h010000));
		bodies_pending.push_back(body(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			24'hFFFFFF, 24'hFFFFFF));
		bodies_pending.push_back(body(32'hFFFF_0000, 0, 32'h7FFF_FFFF, 0, 24'h010000, 24'h010000));
		bodies_pending.push_back(body(32'h0001_0000, 32'h0001_0000, 32'h8000_0000, 32'h8000_0000,
			24'h010000, 24'h010000));
		bodies_pending.push_back(body(32'h0005_0000, 32'hFFFB_0000, 32'h0000_1000, 0, 24'h000000,
			24'h010000));
		bodies_pending.push_back(body(32'h0000_2000, 32'h0000_3000, 0, 0, 24'hFFFFFF, 24'hFFFFFF));
		bodies_pending.push_back(body(32'h7FFF_0000, 32'h7FFF_0000, 32'h0000_0001, 32'hFFFF_FFFF,
			24'h000001, 24'h000001));
		bodies_pending.push_back(body(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
			24'hFFFFFF, 24'h000001));
		bodies_pending.push_back(body(32'hFFF0_0000, 32'h0010_0000, 32'h0123_4567, 32'hFEDC_BA98,
			24'h028000, 24'h006666));
		bodies_pending.push_back(body(32'h0000_0001, 0, 0, 0, 24'h010000, 24'h010000));
		drain();
		run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 60);
		run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 200);
		run_phase(0, 0, 0, 0, 150);
		run_phase(GRAV_CONSTANT_RST, CENTRAL_MASS_RST, MIN_DISTANCE_RST, TIME_STEP_RST, 300);
		run_phase(32'h0000_0100, 32'h0010_0000, 32'h0001_0000, 32'h0000_8000, 200);
		run_phase($urandom, $urandom, $urandom >> 12, $urandom >> 8, 180);
		$display("Checked %0d bodies over 7 register settings: %0d pulled, %0d clamped.",
			bodies_checked, pulls_seen, clamps_seen);
		if (mismatches == 0)
			$display("tb_central_gravity_velocity_update_core: clean");
		else
			$display("tb_central_gravity_velocity_update_core: errors");
		$finish;
	end

	// give up long after the slowest correct run would have finished
	initial begin
		#2000000;
		$display("Timed out with %0d bodies queued and %0d results outstanding.",
			bodies_pending.size(), velocities_due.size());
		$display("tb_central_gravity_velocity_update_core: errors");
		$finish;
	end

endmodule
